/* design/ifct_pkg.sv */
package ifct_pkg;

  localparam logic [1:0] ST_HIT  = 2'd0;
  localparam logic [1:0] ST_NEW  = 2'd1;
  localparam logic [1:0] ST_NON4 = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic        is_ipv4;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] pkt_size;
    logic [15:0] ip_length;
  } item_t;

endpackage

/* design/ifct_front.sv */
module ifct_front #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  ifct_pkg::item_t  in_item,
  input  logic             pop,
  output logic             q_valid,
  output ifct_pkg::item_t  q_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ifct_pkg::item_t fifo [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          push;

  assign busy    = (count == (AW+1)'(DEPTH));
  assign push    = start && !busy;
  assign q_valid = (count != '0);
  assign q_item  = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= in_item;
    end
  end

endmodule

/* design/ifct_back.sv */
module ifct_back #(
  parameter int BUCKETS = 256,
  parameter int WAYS    = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  ifct_pkg::item_t  q_item,
  output logic             pop,
  output logic             init_busy,
  output logic             done,
  output logic [1:0]       status,
  output logic [31:0]      flow_packets,
  output logic [47:0]      flow_bytes,
  output logic [31:0]      grand_packets,
  output logic [47:0]      grand_bytes
);

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int EW = BW + WW;
  localparam int ENTRIES = BUCKETS * (1 << WW);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;

  logic [WAYS-1:0]  vmem [BUCKETS];
  logic [63:0]      kmem [ENTRIES];
  logic [31:0]      pmem [ENTRIES];
  logic [47:0]      bmem [ENTRIES];

  logic [2:0]       state;
  logic [BW-1:0]    clr_idx;
  ifct_pkg::item_t  cur;
  logic [BW-1:0]    bucket;
  logic [WAYS-1:0]  vbits;
  logic [WW-1:0]    way;
  logic             found;
  logic [WW-1:0]    hit_way;
  logic [WW-1:0]    free_way;
  logic             have_free;
  logic [63:0]      rd_key;
  logic [31:0]      rd_pkt;
  logic [47:0]      rd_byt;
  logic [EW-1:0]    rd_addr;
  logic [EW-1:0]    tgt_addr;
  logic [31:0]      new_pkt;
  logic [48:0]      new_byt_w;
  logic [47:0]      new_byt;
  logic [32:0]      gp_inc;
  logic [48:0]      gb_sum;
  logic [63:0]      key;
  logic             way_last;

  assign bucket    = BW'((q_item.src_addr ^ q_item.dst_addr) % BUCKETS);
  assign key       = {cur.src_addr, cur.dst_addr};
  assign rd_addr   = {BW'((cur.src_addr ^ cur.dst_addr) % BUCKETS), way};
  assign tgt_addr  = {BW'((cur.src_addr ^ cur.dst_addr) % BUCKETS),
                      found ? hit_way : free_way};
  assign way_last  = (way == WW'(WAYS-1));
  assign init_busy = (state == S_INIT);
  assign pop       = (state == S_IDLE) && q_valid;

  assign new_pkt   = (!found || rd_pkt == '1) ? (found ? rd_pkt : 32'd1) : rd_pkt + 32'd1;
  assign new_byt_w = (found ? {1'b0, rd_byt} : 49'd0) + {33'd0, cur.pkt_size};
  assign new_byt   = new_byt_w[48] ? '1 : new_byt_w[47:0];
  assign gp_inc    = {1'b0, grand_packets} + 33'd1;
  assign gb_sum    = {1'b0, grand_bytes} + {33'd0, cur.ip_length};

  always_ff @(posedge clk) begin
    if (state == S_INIT) begin
      vmem[clr_idx] <= '0;
    end else if (state == S_WRITE && (found || have_free)) begin
      vmem[BW'((cur.src_addr ^ cur.dst_addr) % BUCKETS)] <= vbits | (WAYS'(1) << tgt_addr[WW-1:0]);
    end
    if (state == S_IDLE && q_valid) begin
      vbits <= vmem[bucket];
    end
  end

  // key and counters of the way under scan; a hit holds the way into S_WRITE
  always_ff @(posedge clk) begin
    rd_key <= kmem[rd_addr];
    rd_pkt <= pmem[rd_addr];
    rd_byt <= bmem[rd_addr];
    if (state == S_WRITE && (found || have_free)) begin
      kmem[tgt_addr] <= key;
      pmem[tgt_addr] <= new_pkt;
      bmem[tgt_addr] <= new_byt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_INIT;
      clr_idx       <= '0;
      way           <= '0;
      found         <= 1'b0;
      hit_way       <= '0;
      free_way      <= '0;
      have_free     <= 1'b0;
      done          <= 1'b0;
      grand_packets <= '0;
      grand_bytes   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_INIT: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == BW'(BUCKETS-1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            way       <= '0;
            found     <= 1'b0;
            have_free <= 1'b0;
            if (!q_item.is_ipv4) begin
              status        <= ifct_pkg::ST_NON4;
              flow_packets  <= '0;
              flow_bytes    <= '0;
              grand_packets <= (grand_packets == '1) ? grand_packets : gp_inc[31:0];
              done          <= 1'b1;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (vbits[way] && rd_key == key) begin
            found   <= 1'b1;
            hit_way <= way;
            state   <= S_WRITE;
          end else begin
            if (!vbits[way] && !have_free) begin
              have_free <= 1'b1;
              free_way  <= way;
            end
            if (way_last) begin
              state <= S_WRITE;
            end else begin
              way   <= way + 1'b1;
              state <= S_READ;
            end
          end
        end
        S_WRITE: begin
          state <= S_IDLE;
          done  <= 1'b1;
          if (found || have_free) begin
            status        <= found ? ifct_pkg::ST_HIT : ifct_pkg::ST_NEW;
            flow_packets  <= new_pkt;
            flow_bytes    <= new_byt;
            grand_packets <= (grand_packets == '1) ? grand_packets : gp_inc[31:0];
            grand_bytes   <= gb_sum[48] ? '1 : gb_sum[47:0];
          end else begin
            status       <= ifct_pkg::ST_FULL;
            flow_packets <= '0;
            flow_bytes   <= '0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/ipv4_flow_counter_table_unit.sv */
// channel  | handshake          | fields
// ---------+--------------------+-----------------------------------------------
// packet   | start / busy       | is_ipv4 src_addr dst_addr pkt_size ip_length
// result   | done (one cycle)   | status flow_packets flow_bytes grand_packets
//          |                    | grand_bytes
// done follows acceptance once the queue hands a transaction to the back end;
// a non-IPv4 transaction finishes from S_IDLE, while an IPv4 one is held in
// S_READ and S_SCAN for each way searched (the key memory reads one way per
// step), then in S_WRITE. After reset busy holds while the valid bits clear.
// A two-entry queue takes transactions while the back end works; results
// cannot be stalled.
module ipv4_flow_counter_table_unit #(
  parameter int BUCKETS = 256,
  parameter int WAYS    = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        is_ipv4,
  input  logic [31:0] src_addr,
  input  logic [31:0] dst_addr,
  input  logic [15:0] pkt_size,
  input  logic [15:0] ip_length,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] flow_packets,
  output logic [47:0] flow_bytes,
  output logic [31:0] grand_packets,
  output logic [47:0] grand_bytes
);

  ifct_pkg::item_t in_item;
  ifct_pkg::item_t q_item;
  logic            q_valid;
  logic            pop;
  logic            init_busy;
  logic            q_full;

  assign in_item = '{is_ipv4, src_addr, dst_addr, pkt_size, ip_length};
  assign busy    = q_full || init_busy;

  ifct_front #(.DEPTH(2)) u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start && !init_busy),
    .busy    (q_full),
    .in_item (in_item),
    .pop     (pop),
    .q_valid (q_valid),
    .q_item  (q_item)
  );

  ifct_back #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .pop           (pop),
    .init_busy     (init_busy),
    .done          (done),
    .status        (status),
    .flow_packets  (flow_packets),
    .flow_bytes    (flow_bytes),
    .grand_packets (grand_packets),
    .grand_bytes   (grand_bytes)
  );

endmodule

/* verif/flow_table_checker.sv */
module flow_table_checker #(
  parameter int BUCKETS = 256,
  parameter int WAYS    = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        is_ipv4,
  input  logic [31:0] src_addr,
  input  logic [31:0] dst_addr,
  input  logic [15:0] pkt_size,
  input  logic [15:0] ip_length,
  input  logic        done,
  input  logic [1:0]  status,
  input  logic [31:0] flow_packets,
  input  logic [47:0] flow_bytes,
  input  logic [31:0] grand_packets,
  input  logic [47:0] grand_bytes,
  output int          errors,
  output int          pending
);

  localparam int ENTRIES = BUCKETS * WAYS;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] flow_packets;
    logic [47:0] flow_bytes;
    logic [31:0] grand_packets;
    logic [47:0] grand_bytes;
  } flow_result_t;

  logic        ent_valid [ENTRIES];
  logic [63:0] ent_key   [ENTRIES];
  logic [31:0] ent_pkts  [ENTRIES];
  logic [47:0] ent_bytes [ENTRIES];
  logic [31:0] tot_pkts;
  logic [47:0] tot_bytes;
  flow_result_t expected_q[$];

  function automatic logic [31:0] inc_sat32(logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  function automatic logic [47:0] add_sat48(logic [47:0] v, logic [15:0] a);
    logic [48:0] s;
    s = {1'b0, v} + 49'(a);
    return s[48] ? '1 : s[47:0];
  endfunction

  function automatic flow_result_t update_flow_table(ifct_pkg::item_t it);
    flow_result_t r;
    int base, hit, free_way, e;
    logic [63:0] key;
    r = '0;
    if (!it.is_ipv4) begin
      tot_pkts = inc_sat32(tot_pkts);
      r.status = ifct_pkg::ST_NON4;
    end else begin
      base = int'((it.src_addr ^ it.dst_addr) % BUCKETS) * WAYS;
      key = {it.src_addr, it.dst_addr};
      hit = -1;
      free_way = -1;
      for (int w = 0; w < WAYS; w++) begin
        if (ent_valid[base + w]) begin
          if (hit < 0 && ent_key[base + w] == key) hit = base + w;
        end else if (free_way < 0) begin
          free_way = base + w;
        end
      end
      if (hit < 0 && free_way < 0) begin
        r.status = ifct_pkg::ST_FULL;
      end else begin
        if (hit >= 0) begin
          e = hit;
          r.status = ifct_pkg::ST_HIT;
        end else begin
          e = free_way;
          ent_valid[e] = 1'b1;
          ent_key[e] = key;
          ent_pkts[e] = '0;
          ent_bytes[e] = '0;
          r.status = ifct_pkg::ST_NEW;
        end
        ent_pkts[e] = inc_sat32(ent_pkts[e]);
        ent_bytes[e] = add_sat48(ent_bytes[e], it.pkt_size);
        r.flow_packets = ent_pkts[e];
        r.flow_bytes = ent_bytes[e];
        tot_pkts = inc_sat32(tot_pkts);
        tot_bytes = add_sat48(tot_bytes, it.ip_length);
      end
    end
    r.grand_packets = tot_pkts;
    r.grand_bytes = tot_bytes;
    return r;
  endfunction

  task automatic compare_field(string name, logic [47:0] exp_v, logic [47:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      if (errors <= 10)
        $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    flow_result_t exp_r;
    ifct_pkg::item_t it;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) ent_valid[i] = 1'b0;
      tot_pkts = '0;
      tot_bytes = '0;
      expected_q.delete();
      errors = 0;
    end else begin
      if (done) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t: result with no transaction pending", $realtime);
        end else begin
          exp_r = expected_q.pop_front();
          compare_field("status", 48'(exp_r.status), 48'(status));
          compare_field("flow_packets", 48'(exp_r.flow_packets), 48'(flow_packets));
          compare_field("flow_bytes", exp_r.flow_bytes, flow_bytes);
          compare_field("grand_packets", 48'(exp_r.grand_packets), 48'(grand_packets));
          compare_field("grand_bytes", exp_r.grand_bytes, grand_bytes);
        end
      end
      if (start && !busy) begin
        it = '{is_ipv4, src_addr, dst_addr, pkt_size, ip_length};
        expected_q.push_back(update_flow_table(it));
      end
    end
    pending = expected_q.size();
  end

endmodule

/* verif/testbench.sv */
module testbench;

  localparam int LIMIT = 400000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        is_ipv4;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [15:0] pkt_size;
  logic [15:0] ip_length;
  logic        done;
  logic [1:0]  status;
  logic [31:0] flow_packets;
  logic [47:0] flow_bytes;
  logic [31:0] grand_packets;
  logic [47:0] grand_bytes;
  int          errors;
  int          pending;
  int          cycles;
  int          sent;
  int          idle_pct;
  logic [31:0] pool_src [24];
  logic [31:0] pool_dst [24];

  ipv4_flow_counter_table_unit u_dut (.*);

  flow_table_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // drive one transaction and hold it until accepted
  task automatic send_packet(ifct_pkg::item_t it);
    is_ipv4 = it.is_ipv4;
    src_addr = it.src_addr;
    dst_addr = it.dst_addr;
    pkt_size = it.pkt_size;
    ip_length = it.ip_length;
    start = 1'b1;
    do @(posedge clk); while (busy);
    sent++;
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  function automatic ifct_pkg::item_t flow_pkt(logic [31:0] s, logic [31:0] d);
    return '{1'b1, s, d, 16'($urandom), 16'($urandom)};
  endfunction

  function automatic ifct_pkg::item_t random_pkt();
    ifct_pkg::item_t it;
    int sel;
    sel = $urandom_range(99);
    if (sel < 65) begin
      sel = $urandom_range(23);
      it = flow_pkt(pool_src[sel], pool_dst[sel]);
    end else if (sel < 77) begin
      it = flow_pkt($urandom, $urandom);
      it.is_ipv4 = 1'b0;
    end else begin
      it = flow_pkt($urandom, $urandom);
    end
    return it;
  endfunction

  task automatic drain();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    logic [31:0] s;
    logic [7:0]  bkt;
    cycles = 0;
    sent = 0;
    idle_pct = 0;
    rst = 1'b1;
    start = 1'b0;
    is_ipv4 = 1'b0;
    src_addr = '0;
    dst_addr = '0;
    pkt_size = '0;
    ip_length = '0;
    // four crowded buckets of six flows each
    for (int i = 0; i < 24; i++) begin
      bkt = 8'($urandom_range(255));
      if (i % 6 == 0) bkt = 8'(i * 37 + 3);
      else bkt = 8'((i / 6) * 6 * 37 + 3);
      s = $urandom;
      pool_src[i] = s;
      pool_dst[i] = {24'($urandom), 8'h0} | 32'(s[7:0] ^ bkt);
    end
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // directed: extremes, hit, non-IPv4, full bucket
    send_packet('{1'b1, 32'h0, 32'h0, 16'h0, 16'h0});
    send_packet('{1'b1, 32'h0, 32'h0, 16'hFFFF, 16'hFFFF});
    send_packet('{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF});
    send_packet('{1'b0, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'hFFFF});
    send_packet('{1'b0, 32'h0, 32'hFFFF_FFFF, 16'h0, 16'h0});
    for (int i = 0; i < 6; i++) begin
      s = 32'h1000_0000 + 32'(i << 8);
      send_packet(flow_pkt(s, s ^ 32'h0000_005A));
    end
    send_packet(flow_pkt(32'h1000_0100, 32'h1000_015A));
    send_packet(flow_pkt(32'h1000_0500, 32'h1000_055A));
    send_packet('{1'b1, 32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h8000});
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 32 : (ph == 1) ? 87 : 0;
      for (int n = 0; n < 200; n++) begin
        if (n == 100) drain();
        send_packet(random_pkt());
      end
    end
    drain();
    repeat (20) @(negedge clk);

    $display("Sent %0d packet transactions: new, repeated, non-IPv4 and full-bucket cases,",
             sent);
    $display("under light, heavy and no sender pacing.");
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* filelist.f */
design/ifct_pkg.sv
design/ifct_front.sv
design/ifct_back.sv
design/ipv4_flow_counter_table_unit.sv
verif/flow_table_checker.sv
verif/testbench.sv
